// File: src/triangle_wind_force_top_macros.svh
// Assertion helpers for the triangle wind force block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TRIANGLE_WIND_FORCE_TOP_MACROS_SVH
`define TRIANGLE_WIND_FORCE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TWF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define TWF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TWF_ASSERT(lbl, cond, msg)
`define TWF_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// File: src/twf_pkg.sv
`default_nettype none
package twf_pkg;
	localparam int COORD_BITS = 24;
	localparam int FIELD_W    = 24;
	localparam int WIND_W     = 24;
	localparam int OUT_W      = 48;
	localparam int FRAC_W     = 24;

	localparam int EDGE_W  = COORD_BITS + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int NRM_W   = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int LEN_W   = $clog2(MAG_W + 1);
	localparam int R_W     = 30;
	localparam int SHF_W   = (MAG_W > R_W) ? MAG_W : R_W;
	localparam int SQ_W    = 2 * R_W;
	localparam int SUMSQ_W = SQ_W + 2;
	localparam int RW_W    = R_W + 1 + WIND_W;
	localparam int DOT_W   = RW_W + 2;
	localparam int ABS_W   = DOT_W;
	localparam int L_W     = SUMSQ_W / 2;

	localparam int SQ_IT     = SUMSQ_W / 2 + 1;
	localparam int V_W       = 2 * SQ_IT;
	localparam int SQ_PER    = 2;
	localparam int SQ_STAGES = (SQ_IT + SQ_PER - 1) / SQ_PER;

	localparam int S_W        = 26;
	localparam int DIV_STEPS  = S_W;
	localparam int DIV_PER    = 2;
	localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

	localparam int LO_W  = S_W;
	localparam int HI_W  = MAG_W - LO_W;
	localparam int P_W   = MAG_W + S_W;
	localparam int PS_W  = ((P_W - FRAC_W) > (OUT_W + 1)) ? (P_W - FRAC_W) : (OUT_W + 1);

	typedef enum logic [1:0] {
		REG_WIND_X     = 2'd0,
		REG_WIND_Y     = 2'd1,
		REG_WIND_Z     = 2'd2,
		REG_SHOW_TEARS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] first_x;
		logic signed [FIELD_W-1:0] first_y;
		logic signed [FIELD_W-1:0] first_z;
		logic signed [FIELD_W-1:0] second_x;
		logic signed [FIELD_W-1:0] second_y;
		logic signed [FIELD_W-1:0] second_z;
		logic signed [FIELD_W-1:0] third_x;
		logic signed [FIELD_W-1:0] third_y;
		logic signed [FIELD_W-1:0] third_z;
		logic                      first_broken;
		logic                      second_broken;
		logic                      third_broken;
	} in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] force_x;
		logic signed [OUT_W-1:0] force_y;
		logic signed [OUT_W-1:0] force_z;
		logic                    applied;
	} out_t;

	typedef struct packed {
		logic signed [WIND_W-1:0] wind_x;
		logic signed [WIND_W-1:0] wind_y;
		logic signed [WIND_W-1:0] wind_z;
		logic                     show_tears;
	} cfg_t;

	// Side data that rides along the root and divide pipelines.
	typedef struct packed {
		logic [2:0][MAG_W-1:0]   mag;
		logic [2:0]              neg;
		logic                    skip;
		logic                    degen;
		logic signed [DOT_W-1:0] dot;
	} carry_t;
endpackage
`default_nettype wire

// File: src/twf_front.sv
`default_nettype none
module twf_front import twf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  in_t                item,
	input  cfg_t               cfg,
	output logic               sum_vld,
	output logic [SUMSQ_W-1:0] sumsq,
	output carry_t             side
);
	function automatic logic signed [EDGE_W-1:0] sx(input logic [FIELD_W-1:0] f);
		logic [COORD_BITS-1:0] c;
		begin
			c = COORD_BITS'(f);
			return EDGE_W'(signed'(c));
		end
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [EDGE_W-1:0] e1_s1 [3];
	logic signed [EDGE_W-1:0] e2_s1 [3];
	logic                     skip_s1, skip_s2, skip_s3;
	logic signed [PROD_W-1:0] p_s2 [6];
	logic [MAG_W-1:0]         mag_s3 [3];
	logic [2:0]               neg_s3;
	carry_t                   side_s4, side_s5, side_s6, side_s7;
	logic [LEN_W-1:0]         sh_s4;
	logic signed [R_W:0]      r_s5 [3];
	logic [R_W-1:0]           q_s5 [3];
	logic [SQ_W-1:0]          sq_s6 [3];
	logic signed [RW_W-1:0]   rw_s6 [3];
	logic [SUMSQ_W-1:0]       sumsq_s7;

	logic signed [NRM_W-1:0]  n_c [3];
	logic [MAG_W-1:0]         orv_c;
	logic [LEN_W-1:0]         len_c;
	logic [LEN_W-1:0]         sh_c;
	logic [SHF_W-1:0]         shf_c [3];
	logic signed [WIND_W-1:0] w_c [3];

	assign w_c[0] = cfg.wind_x;
	assign w_c[1] = cfg.wind_y;
	assign w_c[2] = cfg.wind_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Cross product terms, reduce and shift helpers.
	always_comb begin
		n_c[0] = NRM_W'(p_s2[0]) - NRM_W'(p_s2[1]);
		n_c[1] = NRM_W'(p_s2[2]) - NRM_W'(p_s2[3]);
		n_c[2] = NRM_W'(p_s2[4]) - NRM_W'(p_s2[5]);
		orv_c = mag_s3[0] | mag_s3[1] | mag_s3[2];
		len_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (orv_c[i]) begin
				len_c = LEN_W'(i + 1);
			end
		end
		sh_c = (len_c > LEN_W'(R_W)) ? (len_c - LEN_W'(R_W)) : '0;
		for (int i = 0; i < 3; i++) begin
			shf_c[i] = SHF_W'(side_s4.mag[i]) >> sh_s4;
		end
	end

	always_ff @(posedge clk) begin
		e1_s1[0] <= sx(item.second_x) - sx(item.first_x);
		e1_s1[1] <= sx(item.second_y) - sx(item.first_y);
		e1_s1[2] <= sx(item.second_z) - sx(item.first_z);
		e2_s1[0] <= sx(item.third_x) - sx(item.first_x);
		e2_s1[1] <= sx(item.third_y) - sx(item.first_y);
		e2_s1[2] <= sx(item.third_z) - sx(item.first_z);
		skip_s1  <= !cfg.show_tears && item.first_broken && item.second_broken
			&& item.third_broken;

		p_s2[0] <= e1_s1[1] * e2_s1[2];
		p_s2[1] <= e1_s1[2] * e2_s1[1];
		p_s2[2] <= e1_s1[2] * e2_s1[0];
		p_s2[3] <= e1_s1[0] * e2_s1[2];
		p_s2[4] <= e1_s1[0] * e2_s1[1];
		p_s2[5] <= e1_s1[1] * e2_s1[0];
		skip_s2 <= skip_s1;

		for (int i = 0; i < 3; i++) begin
			neg_s3[i] <= n_c[i][NRM_W-1];
			mag_s3[i] <= n_c[i][NRM_W-1] ? MAG_W'(-n_c[i]) : MAG_W'(n_c[i]);
		end
		skip_s3 <= skip_s2;

		for (int i = 0; i < 3; i++) begin
			side_s4.mag[i] <= mag_s3[i];
		end
		side_s4.neg   <= neg_s3;
		side_s4.skip  <= skip_s3;
		side_s4.degen <= (orv_c == '0);
		side_s4.dot   <= '0;
		sh_s4         <= sh_c;

		for (int i = 0; i < 3; i++) begin
			q_s5[i] <= shf_c[i][R_W-1:0];
			r_s5[i] <= side_s4.neg[i] ? -$signed({1'b0, shf_c[i][R_W-1:0]})
				: $signed({1'b0, shf_c[i][R_W-1:0]});
		end
		side_s5 <= side_s4;

		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= q_s5[i] * q_s5[i];
			rw_s6[i] <= r_s5[i] * w_c[i];
		end
		side_s6 <= side_s5;

		sumsq_s7 <= SUMSQ_W'(sq_s6[0]) + SUMSQ_W'(sq_s6[1]) + SUMSQ_W'(sq_s6[2]);
		side_s7.mag   <= side_s6.mag;
		side_s7.neg   <= side_s6.neg;
		side_s7.skip  <= side_s6.skip;
		side_s7.degen <= side_s6.degen;
		side_s7.dot   <= DOT_W'(rw_s6[0]) + DOT_W'(rw_s6[1]) + DOT_W'(rw_s6[2]);
	end

	assign sum_vld = vld_s7;
	assign sumsq   = sumsq_s7;
	assign side    = side_s7;
endmodule
`default_nettype wire

// File: src/twf_sqrt.sv
`default_nettype none
module twf_sqrt import twf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  logic [SUMSQ_W-1:0] rad,
	input  carry_t             side,
	output logic               root_vld,
	output logic [L_W-1:0]     root,
	output carry_t             root_side
);
	function automatic logic [2*V_W-1:0] sq_step(input logic [V_W-1:0] v,
		input logic [V_W-1:0] r, input int it);
		logic [V_W-1:0] b, vv, rr;
		begin
			vv = v;
			rr = r;
			b = V_W'(1) << (V_W - 2 - 2 * it);
			if (it < SQ_IT) begin
				if (vv >= rr + b) begin
					vv = vv - (rr + b);
					rr = (rr >> 1) + b;
				end else begin
					rr = rr >> 1;
				end
			end
			return {vv, rr};
		end
	endfunction

	logic           vld_p [SQ_STAGES+1];
	logic [V_W-1:0] v_p   [SQ_STAGES+1];
	logic [V_W-1:0] r_p   [SQ_STAGES+1];
	carry_t         sd_p  [SQ_STAGES+1];

	assign vld_p[0] = vld;
	assign v_p[0]   = V_W'(rad);
	assign r_p[0]   = '0;
	assign sd_p[0]  = side;

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_stage
		logic [2*V_W-1:0] a_c, b_c;
		always_comb begin
			a_c = sq_step(v_p[j], r_p[j], SQ_PER * j);
			b_c = sq_step(a_c[2*V_W-1:V_W], a_c[V_W-1:0], SQ_PER * j + 1);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[j+1] <= 1'b0;
			end else begin
				vld_p[j+1] <= vld_p[j];
			end
		end
		always_ff @(posedge clk) begin
			v_p[j+1]  <= b_c[2*V_W-1:V_W];
			r_p[j+1]  <= b_c[V_W-1:0];
			sd_p[j+1] <= sd_p[j];
		end
	end

	assign root_vld  = vld_p[SQ_STAGES];
	assign root      = r_p[SQ_STAGES][L_W-1:0];
	assign root_side = sd_p[SQ_STAGES];
endmodule
`default_nettype wire

// File: src/twf_div.sv
`default_nettype none
module twf_div import twf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld,
	input  logic [L_W-1:0] den,
	input  carry_t         side,
	output logic           quot_vld,
	output logic [S_W-1:0] quot,
	output carry_t         quot_side
);
	function automatic logic [ABS_W+S_W-1:0] div_step(input logic [ABS_W-1:0] rem,
		input logic [S_W-1:0] q, input logic [L_W-1:0] d, input int k);
		logic [ABS_W-1:0] rr, dsh;
		logic [S_W-1:0]   qq;
		begin
			rr = rem;
			qq = q;
			if (k >= 0) begin
				dsh = ABS_W'(d) << k;
				if (rr >= dsh) begin
					rr = rr - dsh;
					qq = qq | (S_W'(1) << k);
				end
			end
			return {rr, qq};
		end
	endfunction

	logic             vld_p [DIV_STAGES+1];
	logic [ABS_W-1:0] rem_p [DIV_STAGES+1];
	logic [S_W-1:0]   q_p   [DIV_STAGES+1];
	logic [L_W-1:0]   d_p   [DIV_STAGES+1];
	carry_t           sd_p  [DIV_STAGES+1];

	// Entry stage: take the magnitude of the dot product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p[0] <= 1'b0;
		end else begin
			vld_p[0] <= vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_p[0] <= side.dot[DOT_W-1] ? ABS_W'(-side.dot) : ABS_W'(side.dot);
		q_p[0]   <= '0;
		d_p[0]   <= den;
		sd_p[0]  <= side;
	end

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [ABS_W+S_W-1:0] a_c, b_c;
		always_comb begin
			a_c = div_step(rem_p[j], q_p[j], d_p[j], DIV_STEPS - 1 - DIV_PER * j);
			b_c = div_step(a_c[ABS_W+S_W-1:S_W], a_c[S_W-1:0], d_p[j],
				DIV_STEPS - 2 - DIV_PER * j);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[j+1] <= 1'b0;
			end else begin
				vld_p[j+1] <= vld_p[j];
			end
		end
		always_ff @(posedge clk) begin
			rem_p[j+1] <= b_c[ABS_W+S_W-1:S_W];
			q_p[j+1]   <= b_c[S_W-1:0];
			d_p[j+1]   <= d_p[j];
			sd_p[j+1]  <= sd_p[j];
		end
	end

	assign quot_vld  = vld_p[DIV_STAGES];
	assign quot      = q_p[DIV_STAGES];
	assign quot_side = sd_p[DIV_STAGES];
endmodule
`default_nettype wire

// File: src/twf_back.sv
`default_nettype none
module twf_back import twf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld,
	input  logic [S_W-1:0] quot,
	input  carry_t         side,
	output logic           done,
	output out_t           result
);
	function automatic logic [OUT_W-1:0] sat(input logic neg, input logic [PS_W-1:0] m);
		logic [PS_W-1:0] lim;
		begin
			lim = PS_W'(1) << (OUT_W - 1);
			if (neg) begin
				return (m > lim) ? lim[OUT_W-1:0] : OUT_W'(-m);
			end
			return (m > lim - PS_W'(1)) ? OUT_W'(lim - PS_W'(1)) : m[OUT_W-1:0];
		end
	endfunction

	logic                  vld_b1, vld_b2;
	logic [LO_W+S_W-1:0]   pl_b1 [3];
	logic [HI_W+S_W-1:0]   ph_b1 [3];
	logic [2:0]            sgn_b1;
	logic                  skip_b1, degen_b1;
	out_t                  res_b2;
	logic [P_W-1:0]        p_c [3];
	logic [PS_W-1:0]       m_c [3];
	logic [OUT_W-1:0]      f_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
			vld_b2 <= 1'b0;
		end else begin
			vld_b1 <= vld;
			vld_b2 <= vld_b1;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i] = (P_W'(ph_b1[i]) << LO_W) + P_W'(pl_b1[i]);
			m_c[i] = PS_W'(p_c[i] >> FRAC_W);
			f_c[i] = (skip_b1 || degen_b1) ? '0 : sat(sgn_b1[i], m_c[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pl_b1[i]  <= side.mag[i][LO_W-1:0] * quot;
			ph_b1[i]  <= side.mag[i][MAG_W-1:LO_W] * quot;
			sgn_b1[i] <= side.neg[i] ^ side.dot[DOT_W-1];
		end
		skip_b1  <= side.skip;
		degen_b1 <= side.degen;

		res_b2.force_x <= f_c[0];
		res_b2.force_y <= f_c[1];
		res_b2.force_z <= f_c[2];
		res_b2.applied <= !skip_b1;
	end

	assign done   = vld_b2;
	assign result = res_b2;
endmodule
`default_nettype wire

// File: src/triangle_wind_force_top.sv
// Path: an accepted start runs through front, root, divide and force to the done strobe.
// Throughput: one triangle per cycle; busy never rises and results are not held off.
// Reset: arst_n clears the wind and show_tears registers and every stage valid bit;
//   data registers are not reset.
`default_nettype none
`include "triangle_wind_force_top_macros.svh"
module triangle_wind_force_top import twf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_t                item,
	output logic               done,
	output out_t               result,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [WIND_W-1:0]  cfg_wdata
);
	localparam int LAT = 7 + SQ_STAGES + 1 + DIV_STAGES + 2;

	cfg_t cfg_q;

	logic               sum_vld;
	logic [SUMSQ_W-1:0] sumsq;
	carry_t             sum_side;
	logic               root_vld;
	logic [L_W-1:0]     root;
	carry_t             root_side;
	logic               quot_vld;
	logic [S_W-1:0]     quot;
	carry_t             quot_side;

	// The pipeline never stalls, so a new beat is taken every cycle.
	assign busy = 1'b0;

	// Configuration registers; the user must write them only while the pipeline is empty (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_WIND_X: begin
					cfg_q.wind_x <= cfg_wdata;
				end
				REG_WIND_Y: begin
					cfg_q.wind_y <= cfg_wdata;
				end
				REG_WIND_Z: begin
					cfg_q.wind_z <= cfg_wdata;
				end
				REG_SHOW_TEARS: begin
					cfg_q.show_tears <= cfg_wdata[0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// Edges, cross product, reduction to 30 bits, squares and wind dot product.
	twf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start && !busy),
		.item    (item),
		.cfg     (cfg_q),
		.sum_vld (sum_vld),
		.sumsq   (sumsq),
		.side    (sum_side)
	);

	// Integer square root of the reduced normal's squared length, two bits a stage.
	twf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (sum_vld),
		.rad       (sumsq),
		.side      (sum_side),
		.root_vld  (root_vld),
		.root      (root),
		.root_side (root_side)
	);

	// Restoring divide of |dot| by the length, two quotient bits a stage.
	twf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (root_vld),
		.den       (root),
		.side      (root_side),
		.quot_vld  (quot_vld),
		.quot      (quot),
		.quot_side (quot_side)
	);

	// Scale the full normal by S, drop 24 fraction bits and saturate each component.
	twf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (quot_vld),
		.quot   (quot),
		.side   (quot_side),
		.done   (done),
		.result (result)
	);

	`TWF_ASSERT_IMP(a_done_latency, done, $past(start && !busy, LAT), "done without start")
	`TWF_ASSERT_IMP(a_skip_zero, done && !result.applied, result.force_x == 0 && result.force_y == 0 && result.force_z == 0, "skipped triangle has force")
	`TWF_ASSERT(a_root_nonzero, !(root_vld && !root_side.degen) || root != '0, "zero root")
endmodule
`default_nettype wire
